// ----- src/smt_pkg.sv -----
package smt_pkg;

  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned MaxFire  = 32;
  localparam int unsigned CntW     = $clog2(MaxFire + 1);

  typedef enum logic [2:0] {
    OP_ALLOC = 3'd0,
    OP_FREE  = 3'd1,
    OP_INIT  = 3'd2,
    OP_SET   = 3'd3,
    OP_TICK  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_GRANT = 2'd0,
    KIND_FAIL  = 2'd1,
    KIND_FIRE  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_ALLOC = 2'd1,
    ST_RUN   = 2'd2
  } slot_state_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ALLOC,
    S_U_SUCC,
    S_U_SGET,
    S_U_REQ,
    S_U_CMP,
    S_I_HEAD,
    S_I_HCMP,
    S_I_NEXT,
    S_I_NCMP,
    S_I_LINK1,
    S_I_LINK2,
    S_T_HEAD,
    S_T_CHK
  } fsm_e;

endpackage

// ----- src/sorted_multi_timer_manager_unit.sv -----
// Pool of TIMER_SLOTS one-shot timers kept in a deadline-sorted linked list.
// Slave stream carries one command word: alloc, free, init, set or tick.
// Master stream returns alloc grant/fail words and fired-timer words; tlast
// marks the final word caused by one command, tuser carries the word kind.
// Commands are taken one at a time; tready is high only while idle.
// Each command's walk is paced by the single read port:
//   alloc: scans upward from slot 0 for the lowest free slot
//   init, or free of a timer not running: done in decode
//   unlink of a running timer (free or set): walks from the head to the timer ahead of it
//   set: links into an empty list, at its head, or after walking to its place
//   tick: fires timers from the head until the list is empty or the head stays running
// Fired timers leave in ascending deadline order, later-armed first on ties,
// and at most 32 fire on one tick.
// A registered output word lets the next command enter while the previous
// result still waits; a stalled receiver stalls the sequencer only when a
// new word must be loaded.
// Reset clears all slots to free, the list to empty and the tick count to
// zero; tag, destination and deadline storage hold no reset value.
module sorted_multi_timer_manager_unit #(
  parameter int unsigned TIMER_SLOTS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // op[2:0], slot[7:3], delay[39:8], tag[71:40], dest[73:72], zero pad
  input  logic [smt_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // slot_out[4:0], tag_out[36:5], dest_out[38:37], zero pad
  output logic [smt_pkg::OutDataW-1:0] m_axis_tdata,
  // kind[1:0]
  output logic [1:0]                   m_axis_tuser,
  output logic                         m_axis_tlast
);
  import smt_pkg::*;

  localparam int unsigned IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int unsigned PW = $clog2(TIMER_SLOTS + 1);
  localparam logic [PW-1:0] NoSlot   = PW'(TIMER_SLOTS);
  localparam logic [IW-1:0] LastSlot = IW'(TIMER_SLOTS - 1);

  fsm_e state_q, state_d;

  logic [2:0]  op_q;
  logic [4:0]  slot_q;
  logic [31:0] delay_q;
  logic [31:0] tag_q;
  logic [1:0]  dest_q;

  slot_state_e status_q [TIMER_SLOTS];
  slot_state_e status_d [TIMER_SLOTS];

  logic [PW-1:0]   head_q, head_d;
  logic [31:0]     now_q, now_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic [PW-1:0]   p_q, p_d;
  logic [PW-1:0]   n_q, n_d;
  logic [PW-1:0]   snext_q, snext_d;
  logic [31:0]     dl_q, dl_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pend_q, pend_d;
  logic [PW-1:0]   pslot_q, pslot_d;
  logic [31:0]     ptag_q, ptag_d;
  logic [1:0]      pdest_q, pdest_d;

  logic        out_valid_q;
  logic [1:0]  out_kind_q, out_kind_d;
  logic [4:0]  out_slot_q, out_slot_d;
  logic [31:0] out_tag_q, out_tag_d;
  logic [1:0]  out_dest_q, out_dest_d;
  logic        out_last_q, out_last_d;
  logic        out_load;
  logic        out_free;

  logic [31:0] dl_mem   [TIMER_SLOTS];
  logic [31:0] tag_mem  [TIMER_SLOTS];
  logic [1:0]  dest_mem [TIMER_SLOTS];
  logic [PW-1:0] succ_mem [TIMER_SLOTS];

  logic [IW-1:0] rd_addr;
  logic [31:0]   dl_rd_q;
  logic [31:0]   tag_rd_q;
  logic [1:0]    dest_rd_q;
  logic [PW-1:0] succ_rd_q;

  logic          dl_we;
  logic [31:0]   dl_wdata;
  logic          td_we;
  logic          succ_we;
  logic [IW-1:0] succ_waddr;
  logic [PW-1:0] succ_wdata;

  logic          in_range;
  logic [IW-1:0] slot_ix;
  logic [PW-1:0] s_ptr;
  logic          fire;
  logic          head_none;
  fsm_e          unlink_done;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_range      = (32'(slot_q) < TIMER_SLOTS);
  assign slot_ix       = IW'(slot_q);
  assign s_ptr         = PW'(slot_q);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign head_none     = (head_q == NoSlot);
  assign fire          = (dl_rd_q <= now_q) && (cnt_q < CntW'(MaxFire));
  assign unlink_done   = (op_q == OP_SET) ? S_I_HEAD : S_IDLE;

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q    <= s_axis_tdata[2:0];
      slot_q  <= s_axis_tdata[7:3];
      delay_q <= s_axis_tdata[39:8];
      tag_q   <= s_axis_tdata[71:40];
      dest_q  <= s_axis_tdata[73:72];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dl_we) begin
      dl_mem[slot_ix] <= dl_wdata;
    end
    dl_rd_q <= dl_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (td_we) begin
      tag_mem[slot_ix]  <= tag_q;
      dest_mem[slot_ix] <= dest_q;
    end
    tag_rd_q  <= tag_mem[rd_addr];
    dest_rd_q <= dest_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (succ_we) begin
      succ_mem[succ_waddr] <= succ_wdata;
    end
    succ_rd_q <= succ_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= NoSlot;
      now_q       <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < TIMER_SLOTS; i++) begin
        status_q[i] <= ST_FREE;
      end
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      now_q    <= now_d;
      cnt_q    <= cnt_d;
      pend_q   <= pend_d;
      status_q <= status_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    p_q     <= p_d;
    n_q     <= n_d;
    snext_q <= snext_d;
    dl_q    <= dl_d;
    pslot_q <= pslot_d;
    ptag_q  <= ptag_d;
    pdest_q <= pdest_d;
    if (out_load) begin
      out_kind_q <= out_kind_d;
      out_slot_q <= out_slot_d;
      out_tag_q  <= out_tag_d;
      out_dest_q <= out_dest_d;
      out_last_q <= out_last_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    status_d   = status_q;
    head_d     = head_q;
    now_d      = now_q;
    idx_d      = idx_q;
    p_d        = p_q;
    n_d        = n_q;
    snext_d    = snext_q;
    dl_d       = dl_q;
    cnt_d      = cnt_q;
    pend_d     = pend_q;
    pslot_d    = pslot_q;
    ptag_d     = ptag_q;
    pdest_d    = pdest_q;
    out_load   = 1'b0;
    out_kind_d = KIND_FIRE;
    out_slot_d = 5'(pslot_q);
    out_tag_d  = ptag_q;
    out_dest_d = pdest_q;
    out_last_d = 1'b0;
    rd_addr    = head_q[IW-1:0];
    dl_we      = 1'b0;
    dl_wdata   = delay_q + now_q;
    td_we      = 1'b0;
    succ_we    = 1'b0;
    succ_waddr = slot_ix;
    succ_wdata = head_q;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_IDLE;
        unique case (op_q)
          OP_ALLOC: begin
            idx_d   = '0;
            state_d = S_ALLOC;
          end
          OP_FREE: begin
            if (in_range) begin
              status_d[slot_ix] = ST_FREE;
              if (status_q[slot_ix] == ST_RUN) begin
                state_d = S_U_SUCC;
              end
            end
          end
          OP_INIT: begin
            td_we = in_range;
          end
          OP_SET: begin
            if (in_range && status_q[slot_ix] != ST_FREE) begin
              dl_d              = dl_wdata;
              dl_we             = 1'b1;
              status_d[slot_ix] = ST_RUN;
              state_d = (status_q[slot_ix] == ST_RUN) ? S_U_SUCC : S_I_HEAD;
            end
          end
          OP_TICK: begin
            now_d   = now_q + 32'd1;
            cnt_d   = '0;
            pend_d  = 1'b0;
            state_d = S_T_HEAD;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_ALLOC: begin
        if (status_q[idx_q] == ST_FREE) begin
          if (out_free) begin
            out_load        = 1'b1;
            out_kind_d      = KIND_GRANT;
            out_slot_d      = 5'(idx_q);
            out_tag_d       = '0;
            out_dest_d      = '0;
            out_last_d      = 1'b1;
            status_d[idx_q] = ST_ALLOC;
            state_d         = S_IDLE;
          end
        end else if (idx_q == LastSlot) begin
          if (out_free) begin
            out_load   = 1'b1;
            out_kind_d = KIND_FAIL;
            out_slot_d = '0;
            out_tag_d  = '0;
            out_dest_d = '0;
            out_last_d = 1'b1;
            state_d    = S_IDLE;
          end
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      S_U_SUCC: begin
        rd_addr = slot_ix;
        state_d = S_U_SGET;
      end
      S_U_SGET: begin
        snext_d = succ_rd_q;
        if (head_q == s_ptr) begin
          head_d  = succ_rd_q;
          state_d = unlink_done;
        end else begin
          p_d     = head_q;
          state_d = S_U_REQ;
        end
      end
      S_U_REQ: begin
        rd_addr = p_q[IW-1:0];
        state_d = (p_q == NoSlot) ? unlink_done : S_U_CMP;
      end
      S_U_CMP: begin
        rd_addr = p_q[IW-1:0];
        if (succ_rd_q == s_ptr) begin
          succ_we    = 1'b1;
          succ_waddr = p_q[IW-1:0];
          succ_wdata = snext_q;
          state_d    = unlink_done;
        end else begin
          p_d     = succ_rd_q;
          state_d = S_U_REQ;
        end
      end
      S_I_HEAD: begin
        if (head_none) begin
          succ_we = 1'b1;
          head_d  = s_ptr;
          state_d = S_IDLE;
        end else begin
          state_d = S_I_HCMP;
        end
      end
      S_I_HCMP: begin
        if (dl_q <= dl_rd_q) begin
          succ_we = 1'b1;
          head_d  = s_ptr;
          state_d = S_IDLE;
        end else begin
          p_d     = head_q;
          n_d     = succ_rd_q;
          state_d = S_I_NEXT;
        end
      end
      S_I_NEXT: begin
        rd_addr = n_q[IW-1:0];
        state_d = (n_q == NoSlot) ? S_I_LINK1 : S_I_NCMP;
      end
      S_I_NCMP: begin
        rd_addr = n_q[IW-1:0];
        if (dl_q <= dl_rd_q) begin
          state_d = S_I_LINK1;
        end else begin
          p_d     = n_q;
          n_d     = succ_rd_q;
          state_d = S_I_NEXT;
        end
      end
      S_I_LINK1: begin
        succ_we    = 1'b1;
        succ_waddr = p_q[IW-1:0];
        succ_wdata = s_ptr;
        state_d    = S_I_LINK2;
      end
      S_I_LINK2: begin
        succ_we    = 1'b1;
        succ_wdata = n_q;
        state_d    = S_IDLE;
      end
      S_T_HEAD: begin
        if (head_none) begin
          if (!pend_q) begin
            state_d = S_IDLE;
          end else if (out_free) begin
            out_load   = 1'b1;
            out_last_d = 1'b1;
            pend_d     = 1'b0;
            state_d    = S_IDLE;
          end
        end else begin
          state_d = S_T_CHK;
        end
      end
      S_T_CHK: begin
        if (!pend_q || out_free) begin
          if (pend_q) begin
            out_load   = 1'b1;
            out_last_d = !fire;
          end
          if (fire) begin
            pslot_d                    = head_q;
            ptag_d                     = tag_rd_q;
            pdest_d                    = dest_rd_q;
            pend_d                     = 1'b1;
            status_d[head_q[IW-1:0]]   = ST_ALLOC;
            head_d                     = succ_rd_q;
            cnt_d                      = cnt_q + CntW'(1);
            state_d                    = S_T_HEAD;
          end else begin
            pend_d  = 1'b0;
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_dest_q, out_tag_q, out_slot_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ----- verif/tb_sorted_multi_timer_manager_unit.sv -----
`timescale 1ns / 1ps

module tb_sorted_multi_timer_manager_unit;
  import smt_pkg::*;

  localparam int unsigned Slots      = 32;
  localparam int unsigned ItemTarget = 110;
  localparam int unsigned LongHold   = 400;
  localparam int unsigned EndSettle  = 300;
  localparam int unsigned CycleLimit = 200000;

  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [1:0]  dest;
    logic [31:0] tag;
    logic [31:0] delay;
    logic [4:0]  slot;
    logic [2:0]  op;
  } timer_cmd_t;

  typedef struct {
    kind_e       kind;
    logic [4:0]  slot;
    logic [31:0] tag;
    logic [1:0]  dest;
    logic        last;
  } timer_word_t;

  typedef struct {
    logic [2:0]  op;
    logic [4:0]  slot;
    logic [31:0] delay;
    logic [31:0] tag;
    logic [1:0]  dest;
    bit          typed;
    kind_e       kind;
    logic [4:0]  gslot;
  } plan_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  logic                m_axis_tlast;

  sorted_multi_timer_manager_unit #(
    .TIMER_SLOTS(Slots)
  ) DUT (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

  always #2 clk_i = ~clk_i;

  slot_state_e tmr_state [Slots];
  logic [31:0] tmr_due   [Slots];
  logic [31:0] tmr_tag   [Slots];
  logic [1:0]  tmr_dest  [Slots];
  bit          tmr_bound [Slots];
  int          run_list [$];
  logic [31:0] tick_cnt;

  timer_word_t step_words    [$];
  timer_word_t awaited_words [$];
  timer_word_t no_word;

  int errors      = 0;
  int sent_cmds   = 0;
  int words_seen  = 0;
  int fired_seen  = 0;
  int refused_seen = 0;
  int burst_left  = 0;
  int cycles      = 0;

  logic hold_kick = 1'b0;
  logic hold_seen = 1'b0;
  int   rx_hold_left = 0;
  int   rx_mode = 0;
  int   rx_cyc = 0;

  plan_row_t plan [21] = '{
    '{OP_ALLOC, 5'd0,  32'd0,          32'd0,          2'd0, 1'b1, KIND_GRANT, 5'd0},
    '{OP_ALLOC, 5'd0,  32'd0,          32'd0,          2'd0, 1'b1, KIND_GRANT, 5'd1},
    '{OP_INIT,  5'd0,  32'd0,          32'hFFFF_FFFF,  2'd3, 1'b0, KIND_GRANT, 5'd0},
    '{OP_INIT,  5'd1,  32'd0,          32'd0,          2'd0, 1'b0, KIND_GRANT, 5'd0},
    '{OP_SET,   5'd0,  32'd0,          32'd0,          2'd0, 1'b0, KIND_GRANT, 5'd0},
    '{OP_SET,   5'd1,  32'd0,          32'd0,          2'd0, 1'b0, KIND_GRANT, 5'd0},
    '{OP_TICK,  5'd0,  32'd0,          32'd0,          2'd0, 1'b0, KIND_GRANT, 5'd0},
    '{OP_SET,   5'd0,  32'hFFFF_FFFF,  32'd0,          2'd0, 1'b0, KIND_GRANT, 5'd0},
    '{OP_SET,   5'd1,  32'd2,          32'd0,          2'd0, 1'b0, KIND_GRANT, 5'd0},
    '{OP_SET,   5'd1,  32'd1,          32'd0,          2'd0, 1'b0, KIND_GRANT, 5'd0},
    '{OP_TICK,  5'd0,  32'd0,          32'd0,          2'd0, 1'b0, KIND_GRANT, 5'd0},
    '{OP_SET,   5'd0,  32'd5,          32'd0,          2'd0, 1'b0, KIND_GRANT, 5'd0},
    '{OP_FREE,  5'd0,  32'd0,          32'd0,          2'd0, 1'b0, KIND_GRANT, 5'd0},
    '{OP_SET,   5'd0,  32'd0,          32'd0,          2'd0, 1'b0, KIND_GRANT, 5'd0},
    '{OP_TICK,  5'd0,  32'd0,          32'd0,          2'd0, 1'b0, KIND_GRANT, 5'd0},
    '{OP_SPARE_LO, 5'd0,  32'd0,       32'd0,          2'd0, 1'b0, KIND_GRANT, 5'd0},
    '{OP_SPARE_HI, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, 1'b0, KIND_GRANT, 5'd0},
    '{OP_INIT,  5'd31, 32'd0,          32'h1234_5678,  2'd1, 1'b0, KIND_GRANT, 5'd0},
    '{OP_ALLOC, 5'd0,  32'd0,          32'd0,          2'd0, 1'b1, KIND_GRANT, 5'd0},
    '{OP_FREE,  5'd31, 32'd0,          32'd0,          2'd0, 1'b0, KIND_GRANT, 5'd0},
    '{OP_TICK,  5'd0,  32'd0,          32'd0,          2'd0, 1'b0, KIND_GRANT, 5'd0}
  };

  function automatic void drop_from_run_list(input int s);
    foreach (run_list[i]) begin
      if (run_list[i] == s) begin
        run_list.delete(i);
        break;
      end
    end
  endfunction

  function automatic int free_slot_count();
    int n;
    n = 0;
    foreach (tmr_state[i]) begin
      if (tmr_state[i] == ST_FREE) n++;
    end
    return n;
  endfunction

  function automatic void timer_pool_apply(input timer_cmd_t c);
    int s;
    int pos;
    step_words.delete();
    s = int'(c.slot);
    case (c.op)
      OP_ALLOC: begin
        pos = -1;
        for (int i = 0; i < Slots; i++) begin
          if (tmr_state[i] == ST_FREE) begin
            pos = i;
            break;
          end
        end
        if (pos < 0) begin
          step_words.push_back(timer_word_t'{KIND_FAIL, 5'd0, 32'd0, 2'd0, 1'b1});
        end else begin
          tmr_state[pos] = ST_ALLOC;
          step_words.push_back(timer_word_t'{KIND_GRANT, 5'(pos), 32'd0, 2'd0, 1'b1});
        end
      end
      OP_FREE: begin
        if (tmr_state[s] == ST_RUN) drop_from_run_list(s);
        tmr_state[s] = ST_FREE;
      end
      OP_INIT: begin
        tmr_tag[s]   = c.tag;
        tmr_dest[s]  = c.dest;
        tmr_bound[s] = 1'b1;
      end
      OP_SET: begin
        if (tmr_state[s] != ST_FREE) begin
          if (tmr_state[s] == ST_RUN) drop_from_run_list(s);
          tmr_due[s]   = c.delay + tick_cnt;
          tmr_state[s] = ST_RUN;
          pos = run_list.size();
          for (int i = 0; i < run_list.size(); i++) begin
            if (tmr_due[s] <= tmr_due[run_list[i]]) begin
              pos = i;
              break;
            end
          end
          run_list.insert(pos, s);
        end
      end
      OP_TICK: begin
        tick_cnt = tick_cnt + 32'd1;
        while (run_list.size() != 0 && tmr_due[run_list[0]] <= tick_cnt &&
               step_words.size() < MaxFire) begin
          s = run_list.pop_front();
          tmr_state[s] = ST_ALLOC;
          step_words.push_back(timer_word_t'{KIND_FIRE, 5'(s), tmr_tag[s], tmr_dest[s], 1'b0});
        end
        if (step_words.size() != 0) step_words[step_words.size() - 1].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  task automatic send_cmd(input timer_cmd_t c, input bit typed, input timer_word_t typed_word);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'(c);
    do @(posedge clk_i); while (!s_axis_tready);
    timer_pool_apply(c);
    sent_cmds++;
    if (typed) awaited_words.push_back(typed_word);
    else foreach (step_words[i]) awaited_words.push_back(step_words[i]);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    timer_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      words_seen++;
      if (m_axis_tuser == KIND_FIRE) fired_seen++;
      if (m_axis_tuser == KIND_FAIL) refused_seen++;
      if (awaited_words.size() == 0) begin
        $error("unexpected word: kind %0d slot %0d", m_axis_tuser, m_axis_tdata[4:0]);
        errors++;
      end else begin
        want = awaited_words.pop_front();
        check_field("kind", 32'(want.kind), 32'(m_axis_tuser));
        check_field("slot_out", 32'(want.slot), 32'(m_axis_tdata[4:0]));
        check_field("tag_out", want.tag, m_axis_tdata[36:5]);
        check_field("dest_out", 32'(want.dest), 32'(m_axis_tdata[38:37]));
        check_field("last", 32'(want.last), 32'(m_axis_tlast));
      end
    end
  end

  // hold off on request, otherwise stall on a rotating pattern
  always @(posedge clk_i) begin
    rx_cyc <= rx_cyc + 1;
    if (rx_hold_left != 0) begin
      rx_hold_left  <= rx_hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_kick != hold_seen) begin
      hold_seen     <= hold_kick;
      rx_hold_left  <= LongHold;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_cyc % 128 == 0) rx_mode <= $urandom_range(0, 2);
      case (rx_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= (rx_cyc % 5 < 3);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still awaited", cycles,
               awaited_words.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    timer_cmd_t c;
    timer_word_t tw;
    int pick;
    int s;

    foreach (tmr_state[i]) begin
      tmr_state[i] = ST_FREE;
      tmr_bound[i] = 1'b0;
      tmr_due[i]   = '0;
      tmr_tag[i]   = '0;
      tmr_dest[i]  = '0;
    end
    tick_cnt = '0;
    no_word  = timer_word_t'{KIND_GRANT, 5'd0, 32'd0, 2'd0, 1'b0};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      c  = '{dest: plan[i].dest, tag: plan[i].tag, delay: plan[i].delay,
             slot: plan[i].slot, op: plan[i].op};
      tw = timer_word_t'{plan[i].kind, plan[i].gslot, 32'd0, 2'd0, 1'b1};
      send_cmd(c, plan[i].typed, tw);
    end
    drain_results();

    // fill the pool while the receiver holds off, then hit the full pool
    hold_kick <= ~hold_kick;
    c = '0;
    c.op = OP_ALLOC;
    while (free_slot_count() != 0)
      send_cmd(c, 1'b0, no_word);
    repeat (2) send_cmd(c, 1'b0, no_word);

    // arm a batch with close deadlines so ticks fire several at once
    repeat (12) begin
      s = $urandom_range(0, Slots - 1);
      c = '{dest: 2'($urandom_range(0, 3)), tag: $urandom, delay: 32'd0,
            slot: 5'(s), op: OP_INIT};
      send_cmd(c, 1'b0, no_word);
      c.op    = OP_SET;
      c.delay = $urandom_range(0, 2);
      send_cmd(c, 1'b0, no_word);
    end
    c = '0;
    c.op = OP_TICK;
    repeat (3) send_cmd(c, 1'b0, no_word);

    while (sent_cmds < ItemTarget) begin
      if ($urandom_range(0, 99) < 4) drain_results();
      pick = $urandom_range(0, 99);
      c.slot = 5'($urandom_range(0, Slots - 1));
      c.tag  = $urandom;
      c.dest = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0:       c.delay = 32'hFFFF_FFFF;
        1:       c.delay = $urandom;
        2:       c.delay = $urandom_range(5, 40);
        default: c.delay = $urandom_range(0, 4);
      endcase
      if (pick < 18) begin
        c.op = OP_ALLOC;
      end else if (pick < 34) begin
        c.op = OP_INIT;
      end else if (pick < 60) begin
        c.op = OP_SET;
        for (int k = 0; k < 8 && tmr_state[c.slot] == ST_FREE; k++)
          c.slot = 5'($urandom_range(0, Slots - 1));
        if (tmr_state[c.slot] != ST_FREE && !tmr_bound[c.slot]) c.op = OP_INIT;
      end else if (pick < 72) begin
        c.op = OP_FREE;
        if (run_list.size() != 0 && $urandom_range(0, 1) == 0)
          c.slot = 5'(run_list[$urandom_range(0, run_list.size() - 1)]);
      end else if (pick < 95) begin
        c.op = OP_TICK;
      end else begin
        c.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      end
      send_cmd(c, 1'b0, no_word);
    end

    s_axis_tvalid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk_i);
    repeat (EndSettle) @(posedge clk_i);

    $display("ran %0d commands to tick %0d: %0d words checked, %0d timers fired, %0d refusals",
             sent_cmds, tick_cnt, words_seen, fired_seen, refused_seen);
    $display("%0d mismatches or stray words", errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
